### rtl/core/lsrt_pkg.sv
// package for the line segment rectangle trim core
// widths, register indexes and pipeline payload types; no dependencies
`timescale 1ns / 1ps

package lsrt_pkg;

    // coordinate width of every field and register
    localparam int COORD_WIDTH = 16;
    // width of a coordinate difference and of its magnitude
    localparam int DW = COORD_WIDTH + 1;
    // width of the product of two magnitudes
    localparam int PW = 2 * DW;
    // quotient width: quotient stays below the other-axis span
    localparam int QW = DW;
    // number of clip edges: top, bottom, left, right
    localparam int NUM_EDGES = 4;
    // configuration index width
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_A = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_B = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_B = CFG_IDX_W'(3);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [PW-1:0] prod_t;

    // one segment as it travels down the pipeline
    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } item_t;

    // per-edge control that travels beside the divider
    typedef struct packed {
        logic   en;    // edge applies to this segment
        logic   sel2;  // edge moves the second endpoint
        logic   neg;   // intercept offset is negative
        coord_t p0;    // base coordinate on the intercept axis
        coord_t s;     // edge position
    } lane_t;

endpackage

### rtl/core/line_segment_rect_trim_core.sv
// Stages in order: capture, setup, multiply, the bit-per-stage intercept
// dividers (17 stages) and output. Throughput: one segment per cycle; a stall
// at the output holds the whole pipeline in place. Reset: synchronous active-low
// aresetn clears all valid bits and loads the clip registers to 0, 0, 32767, 32767.
`timescale 1ns / 1ps

module line_segment_rect_trim_core import lsrt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    // segment in: start_x, start_y, end_x, end_y from bit 0 up
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [4*COORD_WIDTH-1:0] s_tdata,
    // trimmed segment out: new_start_x, new_start_y, new_end_x, new_end_y from bit 0 up
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [4*COORD_WIDTH-1:0] m_tdata
);

    localparam int W = COORD_WIDTH;

    // clip registers
    coord_t clip_x_a_reg, clip_y_a_reg, clip_x_b_reg, clip_y_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_x_a_reg <= '0;
            clip_y_a_reg <= '0;
            clip_x_b_reg <= coord_t'(32767);
            clip_y_b_reg <= coord_t'(32767);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CLIP_X_A: clip_x_a_reg <= cfg_data;
                REG_CLIP_Y_A: clip_y_a_reg <= cfg_data;
                REG_CLIP_X_B: clip_x_b_reg <= cfg_data;
                REG_CLIP_Y_B: clip_y_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ordered rectangle
    coord_t xlo, xhi, ylo, yhi;
    assign xlo = (clip_x_a_reg < clip_x_b_reg) ? clip_x_a_reg : clip_x_b_reg;
    assign xhi = (clip_x_a_reg < clip_x_b_reg) ? clip_x_b_reg : clip_x_a_reg;
    assign ylo = (clip_y_a_reg < clip_y_b_reg) ? clip_y_a_reg : clip_y_b_reg;
    assign yhi = (clip_y_a_reg < clip_y_b_reg) ? clip_y_b_reg : clip_y_a_reg;

    // whole pipeline moves when the output register can take a beat
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    // stage a: capture
    logic  va_reg;
    item_t item_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_a_reg.x1 <= s_tdata[W-1:0];
            item_a_reg.y1 <= s_tdata[2*W-1:W];
            item_a_reg.x2 <= s_tdata[3*W-1:2*W];
            item_a_reg.y2 <= s_tdata[4*W-1:3*W];
        end
    end

    // stage b: edge tests, differences and magnitudes
    logic          vb_reg;
    item_t         item_b_reg;
    lane_t         lane_b_reg [NUM_EDGES];
    logic [DW-1:0] amag_b_reg [NUM_EDGES];
    logic [DW-1:0] bmag_b_reg [NUM_EDGES];
    logic [DW-1:0] dm_b_reg   [NUM_EDGES];

    lane_t         lane_b_next [NUM_EDGES];
    logic [DW-1:0] amag_b_next [NUM_EDGES];
    logic [DW-1:0] bmag_b_next [NUM_EDGES];
    logic [DW-1:0] dm_b_next   [NUM_EDGES];

    always_comb begin
        coord_t p0, q0, p1, q1, s, qmin, qmax;
        logic signed [DW-1:0] a, b, d;
        for (int e = 0; e < NUM_EDGES; e++) begin
            // top and bottom intercept x at a y; left and right the other way
            if (e < 2) begin
                p0 = item_a_reg.x1; q0 = item_a_reg.y1;
                p1 = item_a_reg.x2; q1 = item_a_reg.y2;
            end else begin
                p0 = item_a_reg.y1; q0 = item_a_reg.x1;
                p1 = item_a_reg.y2; q1 = item_a_reg.x2;
            end
            unique case (e)
                0:       s = ylo;
                1:       s = yhi;
                2:       s = xlo;
                default: s = xhi;
            endcase
            qmin = (q0 < q1) ? q0 : q1;
            qmax = (q0 < q1) ? q1 : q0;
            a = DW'(s) - DW'(q0);
            b = DW'(p1) - DW'(p0);
            d = DW'(q1) - DW'(q0);
            lane_b_next[e].en   = (qmin < s) && (s < qmax) && (p0 != p1);
            lane_b_next[e].sel2 = (e % 2 == 0) ? (q1 < q0) : (q1 > q0);
            lane_b_next[e].neg  = a[DW-1] ^ b[DW-1] ^ d[DW-1];
            lane_b_next[e].p0   = p0;
            lane_b_next[e].s    = s;
            amag_b_next[e] = a[DW-1] ? DW'(-a) : DW'(a);
            bmag_b_next[e] = b[DW-1] ? DW'(-b) : DW'(b);
            dm_b_next[e]   = d[DW-1] ? DW'(-d) : DW'(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_b_reg <= item_a_reg;
            for (int e = 0; e < NUM_EDGES; e++) begin
                lane_b_reg[e] <= lane_b_next[e];
                amag_b_reg[e] <= amag_b_next[e];
                bmag_b_reg[e] <= bmag_b_next[e];
                dm_b_reg[e]   <= dm_b_next[e];
            end
        end
    end

    // stage c: magnitude products
    logic          vc_reg;
    item_t         item_c_reg;
    lane_t         lane_c_reg [NUM_EDGES];
    prod_t         m_c_reg    [NUM_EDGES];
    logic [DW-1:0] dm_c_reg   [NUM_EDGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (adv) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_c_reg <= item_b_reg;
            for (int e = 0; e < NUM_EDGES; e++) begin
                lane_c_reg[e] <= lane_b_reg[e];
                m_c_reg[e]    <= PW'(amag_b_reg[e]) * PW'(bmag_b_reg[e]);
                dm_c_reg[e]   <= dm_b_reg[e];
            end
        end
    end

    // divider stages, with the segment and edge control alongside
    logic [QW-1:0] q_w   [NUM_EDGES];
    logic          rnz_w [NUM_EDGES];

    genvar g;
    generate
        for (g = 0; g < NUM_EDGES; g++) begin : g_div
            lsrt_div u_div (
                .aclk    (aclk),
                .adv     (adv),
                .in_m    (m_c_reg[g]),
                .in_dm   (dm_c_reg[g]),
                .out_q   (q_w[g]),
                .out_rnz (rnz_w[g])
            );
        end
    endgenerate

    logic  vd_reg   [QW];
    item_t item_d_reg [QW];
    lane_t lane_d_reg [QW][NUM_EDGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vd_reg[0] <= vc_reg;
            for (int k = 1; k < QW; k++) begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_d_reg[0] <= item_c_reg;
            lane_d_reg[0] <= lane_c_reg;
            for (int k = 1; k < QW; k++) begin
                item_d_reg[k] <= item_d_reg[k-1];
                lane_d_reg[k] <= lane_d_reg[k-1];
            end
        end
    end

    // final stage: round toward zero, then apply edges in order
    coord_t t_w [NUM_EDGES];

    always_comb begin
        logic signed [W+1:0] base;
        logic signed [W+1:0] res;
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (lane_d_reg[QW-1][e].neg) begin
                base = (W+2)'(lane_d_reg[QW-1][e].p0) - $signed({1'b0, q_w[e]});
                res  = (rnz_w[e] && base >= 1) ? base - 1 : base;
            end else begin
                base = (W+2)'(lane_d_reg[QW-1][e].p0) + $signed({1'b0, q_w[e]});
                res  = (rnz_w[e] && base < 0) ? base + 1 : base;
            end
            t_w[e] = res[W-1:0];
        end
    end

    item_t res_next;

    always_comb begin
        res_next = item_d_reg[QW-1];
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (lane_d_reg[QW-1][e].en) begin
                if (e < 2) begin
                    if (lane_d_reg[QW-1][e].sel2) begin
                        res_next.x2 = t_w[e];
                        res_next.y2 = lane_d_reg[QW-1][e].s;
                    end else begin
                        res_next.x1 = t_w[e];
                        res_next.y1 = lane_d_reg[QW-1][e].s;
                    end
                end else begin
                    if (lane_d_reg[QW-1][e].sel2) begin
                        res_next.x2 = lane_d_reg[QW-1][e].s;
                        res_next.y2 = t_w[e];
                    end else begin
                        res_next.x1 = lane_d_reg[QW-1][e].s;
                        res_next.y1 = t_w[e];
                    end
                end
            end
        end
    end

    // output register
    logic [4*W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vd_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {res_next.y2, res_next.x2, res_next.y1, res_next.x1};
        end
    end

    assign m_tdata = m_tdata_reg;

    // checks
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_rect_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (xlo <= xhi) && (ylo <= yhi))
        else $error("clip rectangle corners out of order");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vd_reg[QW-1]))
        else $error("output beat with no item in last stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vd_reg[QW-1]) && $stable(vc_reg))
        else $error("pipeline moved during stall");

endmodule

### rtl/core/lsrt_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on lsrt_pkg for widths
`timescale 1ns / 1ps

module lsrt_div import lsrt_pkg::*; (
    input  logic          aclk,
    input  logic          adv,
    input  prod_t         in_m,
    input  logic [DW-1:0] in_dm,
    output logic [QW-1:0] out_q,
    output logic          out_rnz
);

    prod_t         rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] dm_reg  [QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int B = QW - 1 - k;
            prod_t         rem_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] dm_in;
            prod_t         trial;
            logic          ge;
            prod_t         rem_next;
            logic [QW-1:0] q_next;

            if (k == 0) begin : g_first
                assign rem_in = in_m;
                assign q_in   = '0;
                assign dm_in  = in_dm;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign dm_in  = dm_reg[k-1];
            end

            // try to take the shifted divisor out of the remainder
            assign trial    = PW'(dm_in) << B;
            assign ge       = rem_in >= trial;
            assign rem_next = ge ? rem_in - trial : rem_in;
            assign q_next   = ge ? (q_in | (QW'(1) << B)) : q_in;

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k] <= rem_next;
                    q_reg[k]   <= q_next;
                end
            end

            if (k < QW - 1) begin : g_dm
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dm_reg[k] <= dm_in;
                    end
                end
            end
        end
    endgenerate

    assign out_q   = q_reg[QW-1];
    assign out_rnz = |rem_reg[QW-1];

endmodule

### bench/line_segment_rect_trim_core_tb.sv
// testbench for the line segment rectangle trim core
// predicts trimmed segments with exact integer intercepts; depends on lsrt_pkg and the core
`timescale 1ns / 1ps

module line_segment_rect_trim_core_tb;
    import lsrt_pkg::*;

    localparam int LATENCY    = 21;
    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_RANDOM = 700;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [4*COORD_WIDTH-1:0] s_tdata;  // start_x, start_y, end_x, end_y from bit 0 up
    logic m_tvalid;
    logic m_tready;
    logic [4*COORD_WIDTH-1:0] m_tdata;  // new_start_x, new_start_y, new_end_x, new_end_y

    line_segment_rect_trim_core dut (.*);

    typedef struct packed {
        coord_t ey;
        coord_t ex;
        coord_t sy;
        coord_t sx;
    } seg_t;

    // trim predictor and queue of expected trimmed segments
    class trim_scoreboard;
        longint xa, ya, xb, yb;
        seg_t pending[$];
        int errors;
        int shown;

        function void reset_regs();
            xa = 0; ya = 0; xb = 32767; yb = 32767;
            pending.delete();
            errors = 0;
            shown = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, coord_t v);
            case (idx)
                REG_CLIP_X_A: xa = v;
                REG_CLIP_Y_A: ya = v;
                REG_CLIP_X_B: xb = v;
                REG_CLIP_Y_B: yb = v;
                default: ;
            endcase
        endfunction

        // p at q = s on line (p0,q0)-(p1,q1), whole value truncated toward zero
        function longint cross_at(longint p0, longint q0, longint p1, longint q1, longint s);
            longint num, d;
            d = q1 - q0;
            num = p0 * d + (s - q0) * (p1 - p0);
            return num / d;
        endfunction

        function void note_segment(seg_t g);
            longint x1, y1, x2, y2, xlo, xhi, ylo, yhi, minx, maxx, miny, maxy;
            longint nx1, ny1, nx2, ny2, t;
            seg_t r;
            x1 = g.sx; y1 = g.sy; x2 = g.ex; y2 = g.ey;
            xlo = xa < xb ? xa : xb; xhi = xa < xb ? xb : xa;
            ylo = ya < yb ? ya : yb; yhi = ya < yb ? yb : ya;
            minx = x1 < x2 ? x1 : x2; maxx = x1 < x2 ? x2 : x1;
            miny = y1 < y2 ? y1 : y2; maxy = y1 < y2 ? y2 : y1;
            nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2;
            // top edge
            if (miny < ylo && ylo < maxy && x1 != x2) begin
                t = cross_at(x1, y1, x2, y2, ylo);
                if (y2 < y1) begin nx2 = t; ny2 = ylo; end
                else begin nx1 = t; ny1 = ylo; end
            end
            // bottom edge
            if (miny < yhi && yhi < maxy && x1 != x2) begin
                t = cross_at(x1, y1, x2, y2, yhi);
                if (y2 > y1) begin nx2 = t; ny2 = yhi; end
                else begin nx1 = t; ny1 = yhi; end
            end
            // left edge
            if (minx < xlo && xlo < maxx && y1 != y2) begin
                t = cross_at(y1, x1, y2, x2, xlo);
                if (x2 < x1) begin nx2 = xlo; ny2 = t; end
                else begin nx1 = xlo; ny1 = t; end
            end
            // right edge
            if (minx < xhi && xhi < maxx && y1 != y2) begin
                t = cross_at(y1, x1, y2, x2, xhi);
                if (x2 > x1) begin nx2 = xhi; ny2 = t; end
                else begin nx1 = xhi; ny1 = t; end
            end
            r.sx = coord_t'(nx1); r.sy = coord_t'(ny1);
            r.ex = coord_t'(nx2); r.ey = coord_t'(ny2);
            pending.push_back(r);
        endfunction

        function void fail(string what);
            errors++;
            if (shown < 10) begin
                shown++;
                $display("mismatch: %s", what);
            end
        endfunction

        function void check_segment(seg_t got);
            seg_t want;
            if (pending.size() == 0) begin
                fail($sformatf("unexpected beat %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.sx !== want.sx) fail($sformatf("new_start_x exp %0d got %0d", want.sx, got.sx));
            if (got.sy !== want.sy) fail($sformatf("new_start_y exp %0d got %0d", want.sy, got.sy));
            if (got.ex !== want.ex) fail($sformatf("new_end_x exp %0d got %0d", want.ex, got.ex));
            if (got.ey !== want.ey) fail($sformatf("new_end_y exp %0d got %0d", want.ey, got.ey));
        endfunction
    endclass

    trim_scoreboard board;
    int  idle_cycles;
    bit  hold_off_req;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_segment(seg_t'(m_tdata));
    end

    // receiver stall pattern plus one long hold-off
    initial begin
        int mode;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    int burst_left;

    task automatic send_segment(seg_t g);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= g;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_segment(g);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // valid stays up between back-to-back writes; set_rect drops it at the end
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, coord_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, v);
    endtask

    task automatic set_rect(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
        write_cfg(REG_CLIP_X_A, xa);
        write_cfg(REG_CLIP_Y_A, ya);
        write_cfg(REG_CLIP_X_B, xb);
        write_cfg(REG_CLIP_Y_B, yb);
        cfg_valid <= 1'b0;
    endtask

    function automatic coord_t rand_coord(int span);
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000);
            default: return coord_t'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic seg_t rand_seg(int span);
        seg_t g;
        g.sx = rand_coord(span); g.sy = rand_coord(span);
        g.ex = rand_coord(span); g.ey = rand_coord(span);
        // some vertical, horizontal or point segments
        case ($urandom_range(0, 9))
            0: g.ex = g.sx;
            1: g.ey = g.sy;
            2: begin g.ex = g.sx; g.ey = g.sy; end
            default: ;
        endcase
        return g;
    endfunction

    initial begin
        seg_t g;
        board = new();
        board.reset_regs();
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        idle_cycles = 0; hold_off_req = 1'b0;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed segments against the reset rectangle
        send_segment({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
        send_segment({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        send_segment({16'sd100, 16'sd50, 16'sd100, -16'sd50});
        send_segment({16'sd50, -16'sd30, -16'sd50, 16'sd50});
        send_segment({16'sd5, 16'sd5, 16'sd5, 16'sd5});
        send_segment({-16'sd7, 16'sd10, 16'sd3, -16'sd10});
        drain();

        // swapped corners, a small box, ties on the edge
        set_rect(16'sd20, 16'sd20, -16'sd20, -16'sd20);
        send_segment({16'sd37, 16'sd40, -16'sd33, -16'sd40});
        send_segment({-16'sd40, 16'sd0, 16'sd40, 16'sd0});
        send_segment({16'sd40, 16'sd1, -16'sd40, -16'sd2});
        send_segment({16'sd20, 16'sd50, 16'sd20, -16'sd50});
        send_segment({16'sd20, 16'sd20, -16'sd20, -16'sd20});
        send_segment({-16'sd3, 16'sd7, 16'sd9, -16'sd5});
        send_segment({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        drain();

        // extreme rectangle
        set_rect(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segment({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        send_segment({16'sd1, 16'sd2, -16'sd3, -16'sd4});
        drain();

        // random phases over several rectangles; one long receiver hold-off
        for (int ph = 0; ph < 7; ph++) begin
            int span;
            span = (ph % 3 == 0) ? 32767 : ((ph % 3 == 1) ? 200 : 3000);
            set_rect(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
            if (ph == 2) hold_off_req = 1'b1;
            for (int i = 0; i < NUM_RANDOM / 7; i++) begin
                g = rand_seg(span + span / 2);
                send_segment(g);
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/lsrt_pkg.sv
rtl/core/lsrt_div.sv
rtl/core/line_segment_rect_trim_core.sv
bench/line_segment_rect_trim_core_tb.sv
